@@ sv/tcc_pkg.sv @@
package tcc_pkg;

    // Screen geometry
    localparam int COLUMNS    = 80;
    localparam int ROWS       = 25;
    localparam int CELL_COUNT = ROWS * COLUMNS;

    localparam int COL_W  = $clog2(COLUMNS);
    localparam int ROW_W  = $clog2(ROWS);
    localparam int ADDR_W = $clog2(CELL_COUNT);

    localparam logic [7:0] LINE_FEED = 8'h0A;
    localparam logic [7:0] NULL_CHAR = 8'h00;

    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_READ  = 1'b1;

    typedef struct packed {
        logic       command;
        logic [7:0] char_code;
        logic [4:0] read_row;
        logic [6:0] read_column;
    } cmd_t;

    typedef struct packed {
        logic [6:0] cursor_column;
        logic [4:0] cursor_row;
        logic [7:0] cell_char;
        logic       scrolled;
    } rsp_t;

endpackage

@@ sv/tcc_ram.sv @@
module tcc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2000
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write through one port, registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

@@ sv/text_console_cursor_scroll.sv @@
// A write passes through the result state before rsp_valid rises; a read first passes
// through the read state. A write that scrolls also zeroes the new bottom row in the
// clear state. One item at a time: a new item is accepted only in the idle state, and
// the single-port character memory and the row clearing sweep keep the block busy.
// Reset: cursor and scroll offset go to zero, then a clearing pass over all CELL_COUNT
// cells zeroes the memory, during which no item is accepted.
module text_console_cursor_scroll (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         cmd_valid,
    output logic         cmd_stall,
    input  tcc_pkg::cmd_t cmd,
    output logic         rsp_valid,
    input  logic         rsp_stall,
    output tcc_pkg::rsp_t rsp
);

    typedef enum logic [4:0] {
        ST_INIT   = 5'b00001,
        ST_IDLE   = 5'b00010,
        ST_READ   = 5'b00100,
        ST_CLEAR  = 5'b01000,
        ST_RESULT = 5'b10000
    } state_t;

    state_t                      state_reg, state_next;
    logic [tcc_pkg::COL_W-1:0]   col_reg, col_next;
    logic [tcc_pkg::ROW_W-1:0]   row_reg, row_next;
    logic [tcc_pkg::ROW_W-1:0]   top_reg, top_next;
    logic [tcc_pkg::ROW_W-1:0]   clr_row_reg, clr_row_next;
    logic [tcc_pkg::ADDR_W-1:0]  init_cnt_reg, init_cnt_next;
    logic [tcc_pkg::COL_W-1:0]   clr_cnt_reg, clr_cnt_next;
    logic                        rd_ok_reg, rd_ok_next;
    tcc_pkg::rsp_t               res_reg, res_next;
    tcc_pkg::rsp_t               rsp_reg, rsp_next;
    logic                        rsp_valid_reg, rsp_valid_next;

    logic                        accept;
    logic                        out_free;
    logic                        mem_we;
    logic [tcc_pkg::ADDR_W-1:0]  mem_addr;
    logic [7:0]                  mem_wdata;
    logic [7:0]                  mem_rdata;

    // Cursor arithmetic for a write
    logic [tcc_pkg::COL_W:0]     col_inc;
    logic [tcc_pkg::ROW_W:0]     row_inc;
    logic                        wr_plain;
    logic                        wr_lf;
    logic                        col_wrap;
    logic                        row_over;
    logic [tcc_pkg::ROW_W:0]     cur_sum;
    logic [tcc_pkg::ROW_W-1:0]   cur_phys;
    logic [tcc_pkg::ADDR_W-1:0]  cur_addr;

    // Read address mapping
    logic                        rd_ok;
    logic [tcc_pkg::ROW_W-1:0]   rd_row;
    logic [tcc_pkg::COL_W-1:0]   rd_col;
    logic [tcc_pkg::ROW_W:0]     rd_sum;
    logic [tcc_pkg::ROW_W-1:0]   rd_phys;
    logic [tcc_pkg::ADDR_W-1:0]  rd_addr;
    logic [tcc_pkg::ADDR_W-1:0]  clr_addr;

    tcc_ram #(
        .WIDTH (8),
        .DEPTH (tcc_pkg::CELL_COUNT)
    ) u_cells (
        .clk   (clk),
        .we    (mem_we),
        .addr  (mem_addr),
        .wdata (mem_wdata),
        .rdata (mem_rdata)
    );

    assign accept    = cmd_valid && (state_reg == ST_IDLE);
    assign cmd_stall = (state_reg != ST_IDLE);
    assign out_free  = !rsp_valid_reg || !rsp_stall;
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // Map the cursor's logical row onto the circular row store
    always_comb
    begin
        cur_sum = {1'b0, row_reg} + {1'b0, top_reg};
        if (cur_sum >= (tcc_pkg::ROW_W+1)'(tcc_pkg::ROWS))
        begin
            cur_sum = cur_sum - (tcc_pkg::ROW_W+1)'(tcc_pkg::ROWS);
        end
        cur_phys = cur_sum[tcc_pkg::ROW_W-1:0];
        cur_addr = tcc_pkg::ADDR_W'(tcc_pkg::ADDR_W'(cur_phys) *
                   tcc_pkg::ADDR_W'(tcc_pkg::COLUMNS)) + tcc_pkg::ADDR_W'(col_reg);
    end

    // Map the requested cell onto the store
    always_comb
    begin
        rd_ok  = (32'(cmd.read_row) < 32'(tcc_pkg::ROWS)) &&
                 (32'(cmd.read_column) < 32'(tcc_pkg::COLUMNS));
        rd_row = tcc_pkg::ROW_W'(cmd.read_row);
        rd_col = tcc_pkg::COL_W'(cmd.read_column);
        rd_sum = {1'b0, rd_row} + {1'b0, top_reg};
        if (rd_sum >= (tcc_pkg::ROW_W+1)'(tcc_pkg::ROWS))
        begin
            rd_sum = rd_sum - (tcc_pkg::ROW_W+1)'(tcc_pkg::ROWS);
        end
        rd_phys = rd_sum[tcc_pkg::ROW_W-1:0];
        rd_addr = tcc_pkg::ADDR_W'(tcc_pkg::ADDR_W'(rd_phys) *
                  tcc_pkg::ADDR_W'(tcc_pkg::COLUMNS)) + tcc_pkg::ADDR_W'(rd_col);
        clr_addr = tcc_pkg::ADDR_W'(tcc_pkg::ADDR_W'(clr_row_reg) *
                   tcc_pkg::ADDR_W'(tcc_pkg::COLUMNS)) + tcc_pkg::ADDR_W'(clr_cnt_reg);
    end

    // Advance the cursor for a write
    always_comb
    begin
        wr_lf    = (cmd.char_code == tcc_pkg::LINE_FEED);
        wr_plain = (cmd.char_code != tcc_pkg::NULL_CHAR) && !wr_lf;
        col_inc  = {1'b0, col_reg} + 1'b1;
        row_inc  = {1'b0, row_reg} + 1'b1;
        col_wrap = wr_lf || (wr_plain &&
                   (col_inc == (tcc_pkg::COL_W+1)'(tcc_pkg::COLUMNS)));
        row_over = col_wrap && (row_inc == (tcc_pkg::ROW_W+1)'(tcc_pkg::ROWS));
    end

    // Sequencer
    always_comb
    begin
        state_next     = state_reg;
        col_next       = col_reg;
        row_next       = row_reg;
        top_next       = top_reg;
        clr_row_next   = clr_row_reg;
        init_cnt_next  = init_cnt_reg;
        clr_cnt_next   = clr_cnt_reg;
        rd_ok_next     = rd_ok_reg;
        res_next       = res_reg;
        rsp_next       = rsp_reg;
        rsp_valid_next = rsp_valid_reg && rsp_stall;
        mem_we         = 1'b0;
        mem_addr       = rd_addr;
        mem_wdata      = cmd.char_code;

        unique case (state_reg)
            ST_INIT:
            begin
                mem_we    = 1'b1;
                mem_addr  = init_cnt_reg;
                mem_wdata = tcc_pkg::NULL_CHAR;
                init_cnt_next = init_cnt_reg + 1'b1;
                if (32'(init_cnt_reg) == tcc_pkg::CELL_COUNT - 1)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    res_next.cell_char = tcc_pkg::NULL_CHAR;
                    res_next.scrolled  = 1'b0;
                    if (cmd.command == tcc_pkg::CMD_READ)
                    begin
                        rd_ok_next = rd_ok;
                        res_next.cursor_column = 7'(col_reg);
                        res_next.cursor_row    = 5'(row_reg);
                        state_next = ST_READ;
                    end
                    else
                    begin
                        // Store the character unless it is NUL or a line feed, then move the cursor
                        mem_we   = wr_plain;
                        mem_addr = cur_addr;
                        col_next = col_wrap ? '0 :
                                   (wr_plain ? col_inc[tcc_pkg::COL_W-1:0] : col_reg);
                        if (row_over)
                        begin
                            row_next     = row_reg;
                            clr_row_next = top_reg;
                            top_next     = (32'(top_reg) == tcc_pkg::ROWS - 1) ?
                                           '0 : top_reg + 1'b1;
                            clr_cnt_next = '0;
                            state_next   = ST_CLEAR;
                        end
                        else
                        begin
                            row_next   = col_wrap ? row_inc[tcc_pkg::ROW_W-1:0] : row_reg;
                            state_next = ST_RESULT;
                        end
                        res_next.cursor_column = 7'(col_next);
                        res_next.cursor_row    = 5'(row_next);
                        res_next.scrolled      = row_over;
                    end
                end
            end
            ST_READ:
            begin
                res_next.cell_char = rd_ok_reg ? mem_rdata : tcc_pkg::NULL_CHAR;
                state_next = ST_RESULT;
            end
            ST_CLEAR:
            begin
                // Zero the old top row, which becomes the new bottom row
                mem_we    = 1'b1;
                mem_addr  = clr_addr;
                mem_wdata = tcc_pkg::NULL_CHAR;
                clr_cnt_next = clr_cnt_reg + 1'b1;
                if (32'(clr_cnt_reg) == tcc_pkg::COLUMNS - 1)
                begin
                    state_next = ST_RESULT;
                end
            end
            ST_RESULT:
            begin
                if (out_free)
                begin
                    rsp_next       = res_reg;
                    rsp_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_INIT;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_INIT;
            col_reg       <= '0;
            row_reg       <= '0;
            top_reg       <= '0;
            init_cnt_reg  <= '0;
            clr_cnt_reg   <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            col_reg       <= col_next;
            row_reg       <= row_next;
            top_reg       <= top_next;
            init_cnt_reg  <= init_cnt_next;
            clr_cnt_reg   <= clr_cnt_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        clr_row_reg <= clr_row_next;
        rd_ok_reg   <= rd_ok_next;
        res_reg     <= res_next;
        rsp_reg     <= rsp_next;
    end

endmodule

@@ sv/tcc_checker.sv @@
module tcc_checker (
    input logic          clk,
    input logic          rst_n,
    input logic          cmd_valid,
    input logic          cmd_stall,
    input tcc_pkg::cmd_t cmd,
    input logic          rsp_valid,
    input logic          rsp_stall,
    input tcc_pkg::rsp_t rsp
);

    // A stalled result item holds
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
        else $error("result item changed while stalled");

    // One item at a time: after an accept the command side stalls
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd_valid && !cmd_stall |=> cmd_stall)
        else $error("item accepted while the previous one is still at work");

    // A scroll leaves the cursor on the last row
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.scrolled |-> rsp.cursor_row == 5'(tcc_pkg::ROWS - 1))
        else $error("scroll result not on the last row");

    // A scroll leaves the cursor at column zero
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.scrolled |-> rsp.cursor_column == 7'd0)
        else $error("scroll result not at column zero");

endmodule

bind text_console_cursor_scroll tcc_checker u_tcc_checker (.*);
